>>> hdl/bcas_pkg.sv
// ----------------------------------------------------------------------------
// bcas_pkg: shared constants for the bounds-checked array search block
// Widths, store depth and command codes used by the top level and its tests.
// ----------------------------------------------------------------------------
package bcas_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned FOUND_W = 11;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Register index 0: active capacity.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

endpackage

>>> hdl/bcas_ram.sv
// ----------------------------------------------------------------------------
// bcas_ram: generic single-port synchronous RAM
// One access per cycle; a write or a read, read data registered.
// ----------------------------------------------------------------------------
module bcas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bounds_checked_array_search.sv
// ----------------------------------------------------------------------------
// bounds_checked_array_search: word store with bounds check and linear search
// Read, write and search requests against a RAM of configurable capacity.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the in channel (cmd_i, index_i, value_i) with a
//   valid/ready handshake; one result per request leaves on the out channel.
//   The block works on one request at a time; in_ready_o is high while it is
//   idle, also while an earlier result still waits in the output register.
//   On acceptance, a write, an unknown command, an out-of-range read and a
//   search at zero capacity go straight to the emit state; an in-range read
//   first waits for the registered RAM read data; a search reads one entry
//   per cycle and compares n entries, where n is the index of the first
//   match plus one, or the capacity. The result reaches the output register
//   as the block turns idle again.
//   A stalled receiver holds the result; a finished request waits until the
//   output register is free, and no new request is taken meanwhile.
//   Reset clears the range flag and the spare word and sets the capacity to
//   1024. There is no clearing pass: RAM entries hold no defined value until
//   written. The capacity register lies at APB byte address 0 and may only be
//   written while no request is in flight.
// ----------------------------------------------------------------------------
module bounds_checked_array_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bcas_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [bcas_pkg::IDX_W-1:0] index_i,
  input  logic [bcas_pkg::WORD_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bcas_pkg::WORD_W-1:0]    read_word_o,
  output logic signed [bcas_pkg::FOUND_W-1:0] found_index_o,
  output logic                           range_error_o,
  output logic                           size_error_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcas_pkg::PADDR_W-1:0]   paddr,
  input  logic [bcas_pkg::PDATA_W-1:0]   pwdata,
  output logic [bcas_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import bcas_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDATA  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CAP_W-1:0]   cap_q;
  logic [CAP_W-1:0]   cap_eff;
  logic               range_q, range_d;
  logic [WORD_W-1:0]  spare_q;
  logic [WORD_W-1:0]  key_q;
  logic [CAP_W-1:0]   ptr_q, ptr_d;
  logic [CAP_W-1:0]   ptr_next;

  logic [WORD_W-1:0]  res_word_q, res_word_d;
  logic [FOUND_W-1:0] res_found_q, res_found_d;
  logic               res_range_q, res_range_d;
  logic               res_size_q, res_size_d;

  logic               out_valid_q;
  logic [WORD_W-1:0]  out_word_q;
  logic [FOUND_W-1:0] out_found_q;
  logic               out_range_q;
  logic               out_size_q;
  logic               out_free;
  logic               emit;

  logic               in_acc;
  logic               in_bounds;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [WORD_W-1:0]  ram_rdata;
  logic               cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Capacities above the store depth saturate.
  assign cap_eff = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // A negative index is always out of range.
  assign in_bounds = !index_i[IDX_W-1] &&
                     (index_i[IDX_W-2:0] < (IDX_W-1)'(cap_eff));

  assign ptr_next = ptr_q + CAP_W'(1);

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (state_q == S_EMIT) && out_free;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = ptr_next[ADDR_W-1:0];
    if (in_acc) begin
      ram_addr = (cmd_i == CMD_SEARCH) ? '0 : index_i[ADDR_W-1:0];
      ram_we   = (cmd_i == CMD_WRITE) && in_bounds;
    end
  end

  bcas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (value_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    range_d     = range_q;
    ptr_d       = ptr_q;
    res_word_d  = res_word_q;
    res_found_d = res_found_q;
    res_range_d = res_range_q;
    res_size_d  = res_size_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_word_d  = '0;
          res_found_d = NOT_FOUND;
          res_size_d  = (cap_q == '0);
          res_range_d = range_q;
          ptr_d       = '0;
          state_d     = S_EMIT;
          case (cmd_i)
            CMD_READ, CMD_WRITE: begin
              range_d     = !in_bounds;
              res_range_d = !in_bounds;
              if (cmd_i == CMD_READ) begin
                if (in_bounds) begin
                  state_d = S_RDATA;
                end else begin
                  res_word_d = spare_q;
                end
              end
            end
            CMD_SEARCH: begin
              if (cap_eff != '0) begin
                state_d = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDATA: begin
        res_word_d = ram_rdata;
        state_d    = S_EMIT;
      end
      S_SEARCH: begin
        // The RAM data of this cycle belongs to entry ptr_q.
        if (ram_rdata == key_q) begin
          res_found_d = FOUND_W'(ptr_q);
          state_d     = S_EMIT;
        end else if (ptr_next == cap_eff) begin
          state_d = S_EMIT;
        end else begin
          ptr_d = ptr_next;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      range_q     <= 1'b0;
      spare_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      range_q <= range_d;
      if (in_acc && (cmd_i == CMD_WRITE) && !in_bounds) begin
        spare_q <= value_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    res_word_q  <= res_word_d;
    res_found_q <= res_found_d;
    res_range_q <= res_range_d;
    res_size_q  <= res_size_d;
    if (in_acc) begin
      key_q <= value_i;
    end
    if (emit) begin
      out_word_q  <= res_word_q;
      out_found_q <= res_found_q;
      out_range_q <= res_range_q;
      out_size_q  <= res_size_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_word_o   = out_word_q;
  assign found_index_o = out_found_q;
  assign range_error_o = out_range_q;
  assign size_error_o  = out_size_q;

  // The scan pointer never reaches the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (ptr_q < cap_eff))
    else $error("search pointer beyond capacity");

  // A reported match lies inside the active range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_found_q != NOT_FOUND)) |->
      (!out_found_q[FOUND_W-1] && (out_found_q < cap_eff)))
    else $error("found index outside capacity");

  // A read or write request sets the range flag from its bounds check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ((cmd_i == CMD_READ) || (cmd_i == CMD_WRITE))) |=>
      (range_q == !$past(in_bounds)))
    else $error("range flag does not follow bounds check");

  // A result is only produced while the block is busy with a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !in_ready_o)
    else $error("result produced while idle");

endmodule

>>> tb/bounds_checked_array_search_tb.sv
// ----------------------------------------------------------------------------
// bounds_checked_array_search_tb: self-checking bench for the word store
// Directed and random read, write and search requests over several capacity
// settings, with bursty requests, a stalling receiver and a predictor.
// ----------------------------------------------------------------------------
module bounds_checked_array_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcas_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [FOUND_W-1:0] found;
    logic               range_err;
    logic               size_err;
  } access_result_t;

  typedef enum {RX_STREAM, RX_CHOPPY, RX_BLOCKED} rx_mode_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         cmd_i       = CMD_READ;
  logic signed [IDX_W-1:0]  index_i     = '0;
  logic [WORD_W-1:0]        value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [WORD_W-1:0]        read_word_o;
  logic signed [FOUND_W-1:0] found_index_o;
  logic                     range_error_o;
  logic                     size_error_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [PADDR_W-1:0]       paddr       = '0;
  logic [PDATA_W-1:0]       pwdata      = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // Predictor state: the store contents as the block should hold them.
  logic [WORD_W-1:0] store_model [DEPTH];
  bit                store_written [DEPTH];
  int unsigned       written_prefix = 0;
  logic [WORD_W-1:0] spare_model    = '0;
  bit                range_model    = 1'b0;
  logic [CAP_W-1:0]  capacity_model = CAP_RESET;

  access_result_t awaited_results [$];

  int mismatch_count = 0;
  int n_requests     = 0;
  int n_checked      = 0;
  int n_hits         = 0;
  int n_misses       = 0;
  int n_cap_settings = 0;
  int burst_left     = 0;

  rx_mode_e rx_mode    = RX_STREAM;
  int       rx_left    = 0;
  int       stall_run  = 0;

  bounds_checked_array_search DUT (.*);

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("%0t ns  MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned usable_entries();
    return (capacity_model > DEPTH) ? DEPTH : int'(capacity_model);
  endfunction

  function automatic access_result_t predict_store_access(input logic [CMD_W-1:0] cmd,
                                                          input logic signed [IDX_W-1:0] idx,
                                                          input logic [WORD_W-1:0] val);
    access_result_t r;
    int             pos;
    int unsigned    ecap;
    int unsigned    i;
    bit             in_range;
    bit             hit;
    ecap  = usable_entries();
    pos   = idx;
    r.word  = '0;
    r.found = NOT_FOUND;
    hit   = 1'b0;
    case (cmd)
      CMD_READ, CMD_WRITE: begin
        in_range    = (pos >= 0) && (pos < int'(ecap));
        range_model = !in_range;
        if (cmd == CMD_WRITE) begin
          if (in_range) begin
            store_model[pos]   = val;
            store_written[pos] = 1'b1;
            while (written_prefix < DEPTH && store_written[written_prefix])
              written_prefix++;
          end else begin
            spare_model = val;
          end
        end else begin
          r.word = in_range ? store_model[pos] : spare_model;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < ecap && !hit; i++) begin
          if (store_model[i] === val) begin
            r.found = FOUND_W'(i);
            hit     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.range_err = range_model;
    r.size_err  = (capacity_model == '0);
    return r;
  endfunction

  // One request on the input channel. Bursts keep valid high from one request
  // to the next; between bursts the sender idles for a random gap.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic signed [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] val);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    index_i    = idx;
    value_i    = val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_results.push_back(predict_store_access(cmd, idx, val));
    n_requests++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_for_results();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic check_capacity_readback();
    logic [PDATA_W-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CAPACITY_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== PDATA_W'(capacity_model))
      report_mismatch("capacity readback", got, PDATA_W'(capacity_model));
  endtask

  // Only called with no request in flight.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CAPACITY_ADDR;
    pwdata  = PDATA_W'(cap);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    capacity_model = cap;
    n_cap_settings++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_capacity_readback();
  endtask

  function automatic logic signed [IDX_W-1:0] out_of_range_index(input int unsigned ecap);
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sh7FFF;
      3:       return IDX_W'(ecap);
      4:       return {1'b1, 15'($urandom)};
      default: return IDX_W'($urandom_range(ecap, 32767));
    endcase
  endfunction

  // Often a word already in the store (three rolls in ten), so that searches and duplicates hit.
  function automatic logic [WORD_W-1:0] pick_word(input int unsigned reach);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3 && reach > 0) return store_model[$urandom_range(0, reach - 1)];
    if (roll == 3) return '0;
    if (roll == 4) return '1;
    return $urandom;
  endfunction

  // Reads and searches never touch an entry that was never written: reads
  // stay in the written prefix, and a search key is taken from that prefix
  // unless every usable entry has been written.
  task automatic send_random_request();
    int unsigned             ecap;
    int unsigned             reach;
    int unsigned             roll;
    logic [CMD_W-1:0]        cmd;
    logic signed [IDX_W-1:0] idx;
    logic [WORD_W-1:0]       val;
    ecap  = usable_entries();
    reach = (written_prefix < ecap) ? written_prefix : ecap;
    roll  = $urandom_range(0, 99);
    idx   = IDX_W'($urandom);
    val   = $urandom;
    if (roll < 30) begin
      cmd = CMD_WRITE;
      val = pick_word(reach);
      if (ecap == 0 || $urandom_range(0, 9) == 0)
        idx = out_of_range_index(ecap);
      else if (written_prefix < ecap && $urandom_range(0, 1) == 0)
        idx = IDX_W'(written_prefix);
      else
        idx = IDX_W'($urandom_range(0, ecap - 1));
    end else if (roll < 60) begin
      cmd = CMD_READ;
      if (reach > 0 && $urandom_range(0, 4) != 0)
        idx = IDX_W'($urandom_range(0, reach - 1));
      else
        idx = out_of_range_index(ecap);
    end else if (roll < 85) begin
      cmd = CMD_SEARCH;
      if (written_prefix >= ecap) begin
        val = ($urandom_range(0, 1) == 0) ? pick_word(reach) : $urandom;
      end else if (reach > 0) begin
        val = store_model[$urandom_range(0, reach - 1)];
      end else begin
        cmd = CMD_WRITE;
        idx = '0;
      end
    end else if (roll < 90) begin
      cmd = CMD_UNUSED;
    end else begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
      idx = out_of_range_index(ecap);
    end
    send_request(cmd, idx, val);
  endtask

  // Receiver: switches between streaming, random chopping and long stalls.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STREAM: out_ready_i = 1'b1;
      RX_CHOPPY: out_ready_i = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_ready_i = 1'b0;
        end else begin
          out_ready_i = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(5, 30);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin : check_result
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request pending", read_word_o, '0);
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        if (want.found !== NOT_FOUND) n_hits++;
        else n_misses++;
        if (read_word_o !== want.word)
          report_mismatch("read_word", read_word_o, want.word);
        if (found_index_o !== want.found)
          report_mismatch("found_index", 32'(found_index_o), 32'(want.found));
        if (range_error_o !== want.range_err)
          report_mismatch("range_error", 32'(range_error_o), 32'(want.range_err));
        if (size_error_o !== want.size_err)
          report_mismatch("size_error", 32'(size_error_o), 32'(want.size_err));
      end
    end
  end

  // Reset capacity, spare word after reset, the top entry, the index
  // extremes, the sticky flag across a search and the unused command.
  task automatic test_reset_state();
    check_capacity_readback();
    send_request(CMD_READ, 16'sd1024, '0);
    send_request(CMD_WRITE, 16'sd0, 32'hFFFF_FFFF);
    send_request(CMD_READ, 16'sd0, '0);
    send_request(CMD_WRITE, 16'sd1023, 32'h8000_0000);
    send_request(CMD_READ, 16'sd1023, '0);
    send_request(CMD_SEARCH, '0, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, -16'sd1, 32'hA5A5_5A5A);
    send_request(CMD_SEARCH, '0, 32'hFFFF_FFFF);
    send_request(CMD_READ, 16'sh7FFF, '0);
    send_request(CMD_READ, 16'sh8000, '0);
    send_request(CMD_UNUSED, 16'sh7FFF, 32'hFFFF_FFFF);
    send_request(CMD_READ, 16'sd0, '0);
    wait_for_results();
  endtask

  // Duplicate words: the search must return the lowest matching entry.
  task automatic test_small_capacity();
    set_capacity(CAP_W'(4));
    send_request(CMD_WRITE, 16'sd1, '0);
    send_request(CMD_WRITE, 16'sd2, 32'h1234_5678);
    send_request(CMD_WRITE, 16'sd3, '0);
    send_request(CMD_SEARCH, '0, '0);
    send_request(CMD_SEARCH, '0, 32'h1234_5678);
    send_request(CMD_SEARCH, '0, 32'h0BAD_F00D);
    send_request(CMD_READ, 16'sd4, '0);
    wait_for_results();
  endtask

  task automatic test_zero_capacity();
    set_capacity('0);
    send_request(CMD_WRITE, 16'sd0, 32'h0F0F_0F0F);
    send_request(CMD_SEARCH, '0, 32'h0F0F_0F0F);
    wait_for_results();
  endtask

  // Capacity beyond the store depth saturates; old words survive resizes.
  task automatic test_kept_words_and_saturation();
    set_capacity('1);
    send_request(CMD_READ, 16'sd1023, '0);
    send_request(CMD_READ, 16'sd3, '0);
    send_request(CMD_READ, 16'sd1024, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int count);
    set_capacity(cap);
    repeat (count) send_random_request();
    wait_for_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_small_capacity();
    test_zero_capacity();
    test_kept_words_and_saturation();
    test_random_traffic(CAP_W'(1), 60);
    test_random_traffic(CAP_W'(7), 80);
    test_random_traffic(CAP_W'(33), 90);
    test_random_traffic(CAP_W'(1024), 110);
    test_random_traffic('0, 40);
    test_random_traffic(CAP_W'(300), 90);
    test_random_traffic('1, 90);
    test_random_traffic(CAP_W'(16), 80);

    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", awaited_results.size(), '0);

    $display("Sent %0d requests over %0d capacity settings; %0d results compared.",
             n_requests, n_cap_settings, n_checked);
    $display("Searches that found a word: %0d; results without a match: %0d.",
             n_hits, n_misses);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
